// File: sv/ffpa_pkg.sv
// Shared types and constants for the first-fit pool allocator.
// Used by the block table memory, the controller and the top level.
// Depends on nothing.
package ffpa_pkg;

    // Table geometry and pool layout.
    localparam int MAX_BLOCKS   = 256;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int SIZE_W       = 16;
    localparam int POOL_W       = 17;
    localparam int POOL_MIN     = 32;
    localparam int POOL_MAX     = 65536;

    // Command codes.
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_RESIZE = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FIT  = 2'd1;
    localparam logic [1:0] STAT_NULL    = 2'd2;
    localparam logic [1:0] STAT_UNKNOWN = 2'd3;

    // Command transaction.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] request_size;
        logic [15:0] address;
    } cmd_t;

    // Result transaction.
    typedef struct packed {
        logic [15:0] result_address;
        logic [1:0]  status;
    } rsp_t;

    // One block table entry.
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // Access to the block table memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_A_RD,
        ST_A_CHK,
        ST_SU_RD,
        ST_SU_WR,
        ST_SPLIT_HI,
        ST_SPLIT_LO,
        ST_F_RD,
        ST_F_CHK,
        ST_F_NCHK,
        ST_MERGE,
        ST_SD_RD,
        ST_SD_WR
    } state_t;

endpackage

// File: sv/ffpa_mem.sv
// Block table memory: one write port and one registered read port.
// Depends on ffpa_pkg.
module ffpa_mem (
    input  logic              clk,
    input  ffpa_pkg::mem_req_t mreq,
    output ffpa_pkg::entry_t  rd_data
);
    import ffpa_pkg::*;

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
        rd_data_reg <= mem[mreq.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/ffpa_ctrl.sv
// Controller: walks the block table, splits, merges and shifts entries.
// Depends on ffpa_pkg; drives the block table memory ffpa_mem.
module ffpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ffpa_pkg::cmd_t     cmd,
    input  logic               pool_size_we,
    input  logic [16:0]        pool_size,
    input  ffpa_pkg::entry_t   rd_data,
    output ffpa_pkg::mem_req_t mreq,
    output logic               busy,
    output logic               done,
    output ffpa_pkg::rsp_t     rsp
);
    import ffpa_pkg::*;

    localparam logic [POOL_W-1:0] HDR_P   = POOL_W'(HEADER_BYTES);
    localparam logic [POOL_W-1:0] AMASK   = ~POOL_W'(ALIGN_BYTES - 1);
    localparam logic [SIZE_W-1:0] HDR_S   = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] HDR2_S  = SIZE_W'(2 * HEADER_BYTES);
    localparam logic [POOL_W:0]   SPLIT_M = (POOL_W + 1)'(HEADER_BYTES + ALIGN_BYTES);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [POOL_W-1:0] pool_reg, pool_next;
    logic [POOL_W-1:0] need_reg, need_next;
    logic [POOL_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [1:0]        dist_reg, dist_next;
    logic              resize_reg, resize_next;
    entry_t            prev_reg, prev_next;
    entry_t            cur_reg, cur_next;
    entry_t            nxt_reg, nxt_next;
    logic              has_next_reg, has_next_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    logic [POOL_W-1:0] payload;
    logic              fits;
    logic              splits;
    logic              prev_free;
    logic              next_free;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            pool_reg  <= POOL_W'(POOL_MAX);
            count_reg <= CNT_W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pool_reg  <= pool_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        need_reg     <= need_next;
        start_reg    <= start_next;
        idx_reg      <= idx_next;
        src_reg      <= src_next;
        dist_reg     <= dist_next;
        resize_reg   <= resize_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        has_next_reg <= has_next_next;
        rsp_reg      <= rsp_next;
    end

    // Walk helpers.
    assign payload   = start_reg + HDR_P;
    assign fits      = rd_data.free && ({1'b0, rd_data.size} >= need_reg);
    assign splits    = ({2'b0, rd_data.size} >= ({1'b0, need_reg} + SPLIT_M))
                       && (count_reg < CNT_W'(MAX_BLOCKS));
    assign prev_free = (idx_reg != '0) && prev_reg.free;
    assign next_free = has_next_reg && nxt_reg.free;

    // Next state and outputs.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pool_next     = pool_reg;
        need_next     = need_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        src_next      = src_reg;
        dist_next     = dist_reg;
        resize_next   = resize_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        has_next_next = has_next_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        mreq          = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Pool becomes one free block.
                mreq.we         = 1'b1;
                mreq.waddr      = '0;
                mreq.wdata.free = 1'b1;
                mreq.wdata.size = (pool_reg > HDR_P) ? SIZE_W'(pool_reg - HDR_P) : '0;
                count_next      = CNT_W'(1);
                state_next      = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                need_next   = ({1'b0, cmd_reg.request_size} + POOL_W'(ALIGN_BYTES - 1))
                              & AMASK;
                idx_next    = '0;
                start_next  = '0;
                resize_next = (cmd_reg.func == FUNC_RESIZE);
                unique case (cmd_reg.func)
                    FUNC_ALLOC:
                    begin
                        state_next = ST_A_RD;
                    end
                    FUNC_FREE, FUNC_RESIZE:
                    begin
                        if (cmd_reg.address == '0)
                        begin
                            if (cmd_reg.func == FUNC_RESIZE)
                            begin
                                state_next = ST_A_RD;
                            end
                            else
                            begin
                                rsp_next   = '{result_address: '0, status: STAT_NULL};
                                done_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = ST_F_RD;
                        end
                    end
                    default:
                    begin
                        rsp_next   = '{result_address: '0, status: STAT_OK};
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_A_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    rsp_next   = '{result_address: '0, status: STAT_NO_FIT};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mreq.raddr = idx_reg[IDX_W-1:0];
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK:
            begin
                if (fits)
                begin
                    rsp_next = '{result_address: payload[15:0], status: STAT_OK};
                    if (splits)
                    begin
                        cur_next = rd_data;
                        src_next = count_reg - CNT_W'(1);
                        if (count_reg - CNT_W'(1) > idx_reg)
                        begin
                            state_next = ST_SU_RD;
                        end
                        else
                        begin
                            state_next = ST_SPLIT_HI;
                        end
                    end
                    else
                    begin
                        mreq.we         = 1'b1;
                        mreq.waddr      = idx_reg[IDX_W-1:0];
                        mreq.wdata.free = 1'b0;
                        mreq.wdata.size = rd_data.size;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    start_next = payload + {1'b0, rd_data.size};
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_A_RD;
                end
            end
            ST_SU_RD:
            begin
                // Open a slot above the split block, top entry first.
                mreq.raddr = src_reg[IDX_W-1:0];
                state_next = ST_SU_WR;
            end
            ST_SU_WR:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = IDX_W'(src_reg + CNT_W'(1));
                mreq.wdata = rd_data;
                if (src_reg == idx_reg + CNT_W'(1))
                begin
                    state_next = ST_SPLIT_HI;
                end
                else
                begin
                    src_next   = src_reg - CNT_W'(1);
                    state_next = ST_SU_RD;
                end
            end
            ST_SPLIT_HI:
            begin
                mreq.we         = 1'b1;
                mreq.waddr      = IDX_W'(idx_reg + CNT_W'(1));
                mreq.wdata.free = 1'b1;
                mreq.wdata.size = cur_reg.size - need_reg[SIZE_W-1:0] - HDR_S;
                state_next      = ST_SPLIT_LO;
            end
            ST_SPLIT_LO:
            begin
                mreq.we         = 1'b1;
                mreq.waddr      = idx_reg[IDX_W-1:0];
                mreq.wdata.free = 1'b0;
                mreq.wdata.size = need_reg[SIZE_W-1:0];
                count_next      = count_reg + CNT_W'(1);
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_F_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    rsp_next   = '{result_address: '0, status: STAT_UNKNOWN};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mreq.raddr = idx_reg[IDX_W-1:0];
                    state_next = ST_F_CHK;
                end
            end
            ST_F_CHK:
            begin
                if (payload == {1'b0, cmd_reg.address})
                begin
                    cur_next      = rd_data;
                    has_next_next = 1'b0;
                    if (idx_reg + CNT_W'(1) < count_reg)
                    begin
                        mreq.raddr = IDX_W'(idx_reg + CNT_W'(1));
                        state_next = ST_F_NCHK;
                    end
                    else
                    begin
                        state_next = ST_MERGE;
                    end
                end
                else
                begin
                    prev_next  = rd_data;
                    start_next = payload + {1'b0, rd_data.size};
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_F_RD;
                end
            end
            ST_F_NCHK:
            begin
                nxt_next      = rd_data;
                has_next_next = 1'b1;
                state_next    = ST_MERGE;
            end
            ST_MERGE:
            begin
                // Free neighbors never touch each other, so at most three merge.
                mreq.we         = 1'b1;
                mreq.wdata.free = 1'b1;
                if (prev_free && next_free)
                begin
                    mreq.waddr      = IDX_W'(idx_reg - CNT_W'(1));
                    mreq.wdata.size = prev_reg.size + cur_reg.size + nxt_reg.size + HDR2_S;
                    dist_next       = 2'd2;
                    src_next        = idx_reg + CNT_W'(2);
                    state_next      = ST_SD_RD;
                end
                else if (prev_free)
                begin
                    mreq.waddr      = IDX_W'(idx_reg - CNT_W'(1));
                    mreq.wdata.size = prev_reg.size + cur_reg.size + HDR_S;
                    dist_next       = 2'd1;
                    src_next        = idx_reg + CNT_W'(1);
                    state_next      = ST_SD_RD;
                end
                else if (next_free)
                begin
                    mreq.waddr      = idx_reg[IDX_W-1:0];
                    mreq.wdata.size = cur_reg.size + nxt_reg.size + HDR_S;
                    dist_next       = 2'd1;
                    src_next        = idx_reg + CNT_W'(2);
                    state_next      = ST_SD_RD;
                end
                else
                begin
                    mreq.waddr      = idx_reg[IDX_W-1:0];
                    mreq.wdata.size = cur_reg.size;
                    if (resize_reg)
                    begin
                        idx_next   = '0;
                        start_next = '0;
                        state_next = ST_A_RD;
                    end
                    else
                    begin
                        rsp_next   = '{result_address: '0, status: STAT_OK};
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SD_RD:
            begin
                // Close the gap left by merged entries, bottom entry first.
                if (src_reg >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(dist_reg);
                    if (resize_reg)
                    begin
                        idx_next   = '0;
                        start_next = '0;
                        state_next = ST_A_RD;
                    end
                    else
                    begin
                        rsp_next   = '{result_address: '0, status: STAT_OK};
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mreq.raddr = src_reg[IDX_W-1:0];
                    state_next = ST_SD_WR;
                end
            end
            ST_SD_WR:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = IDX_W'(src_reg - CNT_W'(dist_reg));
                mreq.wdata = rd_data;
                src_next   = src_reg + CNT_W'(1);
                state_next = ST_SD_RD;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // A pool size write clamps the value and rebuilds the table.
        if (pool_size_we)
        begin
            if (pool_size < POOL_W'(POOL_MIN))
            begin
                pool_next = POOL_W'(POOL_MIN);
            end
            else if (pool_size > POOL_W'(POOL_MAX))
            begin
                pool_next = POOL_W'(POOL_MAX);
            end
            else
            begin
                pool_next = pool_size;
            end
            state_next = ST_INIT;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: sv/first_fit_pool_allocator.sv
// Top level of the first-fit pool allocator with split and coalesce.
// Depends on ffpa_pkg, ffpa_mem and ffpa_ctrl.
//
// A command is taken when start is high and busy is low; its result shows on
// rsp for exactly one cycle with done high and cannot be held off. One
// command is in flight at a time. Allocate walks the table entries until a
// free block fits and, when the found block is split, moves the entries above
// it up one slot; free walks the entries to find the block, merges it with
// free neighbours and moves the entries above down after a merge. Resize is
// free followed by allocate, or allocate alone for a null address. After
// reset and after every pool_size write, busy stays high for one cycle while
// the table is rebuilt.
module first_fit_pool_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffpa_pkg::cmd_t cmd,
    input  logic           pool_size_we,
    input  logic [16:0]    pool_size,
    output logic           done,
    output ffpa_pkg::rsp_t rsp
);
    import ffpa_pkg::*;

    mem_req_t mreq;
    entry_t   rd_data;

    // Block table storage.
    ffpa_mem u_mem (
        .clk     (clk),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    // Command sequencer.
    ffpa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .pool_size_we (pool_size_we),
        .pool_size    (pool_size),
        .rd_data      (rd_data),
        .mreq         (mreq),
        .busy         (busy),
        .done         (done),
        .rsp          (rsp)
    );

    // A result is only produced by a transaction that was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // An accepted transaction always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !pool_size_we) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Failed and non-allocating results carry a null address.
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STAT_OK) |-> (rsp.result_address == '0))
        else $error("failed transaction returned an address");

endmodule

// File: dv/first_fit_pool_allocator_test.sv
// Self-checking testbench for the first-fit pool allocator.
// Predicts each result from a behavioral copy of the block table.
// Depends on ffpa_pkg and first_fit_pool_allocator.
module first_fit_pool_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2200;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        pool_size_we;
    logic [16:0] pool_size;
    logic        done;
    rsp_t        rsp;

    // Predictor state: a copy of the block table.
    int unsigned pool_bytes;
    int unsigned blk_size [MAX_BLOCKS];
    bit          blk_free [MAX_BLOCKS];
    int unsigned blk_count;
    // Live payload offsets, used to aim frees at real blocks.
    int unsigned live_offsets [$];

    rsp_t        expected_rsp [$];
    int          mismatches;
    int          idle_pct;
    int          idle_count;
    bit          timed_out;

    first_fit_pool_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .pool_size_we (pool_size_we),
        .pool_size    (pool_size),
        .done         (done),
        .rsp          (rsp)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Rebuild the table as one free block.
    function automatic void init_table();
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
        end
        blk_count = 1;
        blk_size[0] = (pool_bytes > HEADER_BYTES) ? pool_bytes - HEADER_BYTES : 0;
        blk_free[0] = 1'b1;
        live_offsets.delete();
    endfunction

    function automatic logic [1:0] alloc_block(input int unsigned req,
                                               output logic [15:0] offset);
        int unsigned need;
        int unsigned base;
        need = (req + 7) & ~32'd7;
        base = 0;
        offset = '0;
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_free[i] && blk_size[i] >= need)
            begin
                // Split off the remainder when it can hold a header and 8 bytes and the table has room.
                if (blk_size[i] >= need + HEADER_BYTES + ALIGN_BYTES &&
                    blk_count < MAX_BLOCKS)
                begin
                    for (int j = blk_count; j > i + 1; j--)
                    begin
                        blk_size[j] = blk_size[j-1];
                        blk_free[j] = blk_free[j-1];
                    end
                    blk_size[i+1] = blk_size[i] - need - HEADER_BYTES;
                    blk_free[i+1] = 1'b1;
                    blk_count++;
                    blk_size[i] = need;
                end
                blk_free[i] = 1'b0;
                offset = 16'(base + HEADER_BYTES);
                live_offsets.push_back(base + HEADER_BYTES);
                return STAT_OK;
            end
            base += HEADER_BYTES + blk_size[i];
        end
        return STAT_NO_FIT;
    endfunction

    function automatic logic [1:0] free_block(input int unsigned addr);
        int unsigned base;
        int          idx;
        int          i;
        base = 0;
        idx = -1;
        for (int k = 0; k < blk_count; k++)
        begin
            if (base + HEADER_BYTES == addr && idx < 0)
                idx = k;
            base += HEADER_BYTES + blk_size[k];
        end
        if (idx < 0)
            return STAT_UNKNOWN;
        blk_free[idx] = 1'b1;
        // Merge every run of adjacent free blocks.
        i = 0;
        while (i + 1 < blk_count)
        begin
            if (blk_free[i] && blk_free[i+1])
            begin
                blk_size[i] += blk_size[i+1] + HEADER_BYTES;
                for (int j = i + 1; j + 1 < blk_count; j++)
                begin
                    blk_size[j] = blk_size[j+1];
                    blk_free[j] = blk_free[j+1];
                end
                blk_count--;
                blk_size[blk_count] = 0;
                blk_free[blk_count] = 1'b0;
            end
            else
                i++;
        end
        return STAT_OK;
    endfunction

    // Apply one command to the table copy and return the expected result.
    function automatic rsp_t predict_allocator(input cmd_t c);
        rsp_t r;
        r = '0;
        if (c.func == FUNC_ALLOC)
            r.status = alloc_block(c.request_size, r.result_address);
        else if (c.func == FUNC_FREE)
            r.status = (c.address == 0) ? STAT_NULL : free_block(c.address);
        else if (c.func == FUNC_RESIZE)
        begin
            if (c.address == 0)
                r.status = alloc_block(c.request_size, r.result_address);
            else
            begin
                r.status = free_block(c.address);
                if (r.status == STAT_OK)
                    r.status = alloc_block(c.request_size, r.result_address);
            end
        end
        return r;
    endfunction

    task automatic idle_gap();
        if ($urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // Send one command and record its expected result.
    task automatic send_cmd(input logic [1:0] f, input int unsigned req,
                            input int unsigned addr);
        cmd_t c;
        c.func = f;
        c.request_size = 16'(req);
        c.address = 16'(addr);
        idle_gap();
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_rsp.push_back(predict_allocator(c));
        start <= 1'b0;
        cmd <= '0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pool(input logic [16:0] val);
        int unsigned v;
        wait_drained();
        pool_size_we <= 1'b1;
        pool_size <= val;
        @(posedge clk);
        pool_size_we <= 1'b0;
        v = val;
        if (v < POOL_MIN) v = POOL_MIN;
        if (v > POOL_MAX) v = POOL_MAX;
        pool_bytes = v;
        init_table();
        @(posedge clk);
    endtask

    // Pick a free/resize address: mostly a live block, sometimes anything.
    function automatic int unsigned pick_address();
        int unsigned k;
        if (live_offsets.size() != 0 && $urandom_range(99) < 80)
        begin
            k = $urandom_range(live_offsets.size() - 1);
            pick_address = live_offsets[k];
            live_offsets.delete(k);
        end
        else if ($urandom_range(9) == 0)
            pick_address = 0;
        else
            pick_address = $urandom_range(16'hFFFF);
    endfunction

    // Directed: extremes, every command and each corner case.
    task automatic test_directed();
        logic [15:0] first;
        send_cmd(FUNC_ALLOC, 0, 0);
        first = 16'(HEADER_BYTES);
        send_cmd(FUNC_ALLOC, 1, 0);
        send_cmd(FUNC_ALLOC, 16'hFFFF, 0);
        send_cmd(FUNC_FREE, 0, 0);
        send_cmd(FUNC_FREE, 0, 16'hFFFF);
        send_cmd(FUNC_FREE, 0, 5);
        send_cmd(FUNC_FREE, 0, first);
        send_cmd(FUNC_FREE, 0, first);
        send_cmd(FUNC_RESIZE, 100, 0);
        send_cmd(FUNC_RESIZE, 40, first);
        send_cmd(FUNC_RESIZE, 40, 16'h1234);
        send_cmd(2'd3, 16'hFFFF, 16'hFFFF);
        send_cmd(FUNC_ALLOC, 65000, 0);
        write_pool(17'd0);
        send_cmd(FUNC_ALLOC, 8, 0);
        send_cmd(FUNC_ALLOC, 0, 0);
        send_cmd(FUNC_FREE, 0, HEADER_BYTES);
        write_pool(17'h1FFFF);
        send_cmd(FUNC_ALLOC, 65512, 0);
        send_cmd(FUNC_FREE, 0, HEADER_BYTES);
        // Fill the table until no split is possible.
        write_pool(17'd20000);
        repeat (260) send_cmd(FUNC_ALLOC, $urandom_range(0, 16), 0);
        send_cmd(FUNC_FREE, 0, HEADER_BYTES);
        send_cmd(FUNC_ALLOC, 0, 0);
    endtask

    // Random: mostly valid alloc/free/resize traffic on a few pool sizes.
    task automatic test_random(input int n, input int pct);
        int unsigned r;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_cmd(FUNC_ALLOC,
                         ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF)
                                                  : $urandom_range(0, 600), 0);
            else if (r < 80)
                send_cmd(FUNC_FREE, $urandom_range(16'hFFFF), pick_address());
            else if (r < 97)
                send_cmd(FUNC_RESIZE, $urandom_range(0, 800), pick_address());
            else
                send_cmd(2'd3, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        end
    endtask

    // Check each result against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result addr=%0d status=%0d",
                             rsp.result_address, rsp.status);
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp.result_address !== e.result_address || rsp.status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                                 e.result_address, e.status,
                                 rsp.result_address, rsp.status);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || pool_size_we)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == WATCHDOG_LIMIT)
            timed_out <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (timed_out)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        pool_size_we = 1'b0;
        pool_size = '0;
        mismatches = 0;
        idle_pct = 0;
        idle_count = 0;
        timed_out = 1'b0;
        pool_bytes = POOL_MAX;
        init_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_pool(17'd2048);
        test_random(280, 0);
        write_pool(17'd4096);
        test_random(280, 74);
        write_pool(17'd32);
        test_random(50, 6);
        write_pool(17'd65536);
        test_random(240, 6);
        write_pool(17'd600);
        test_random(165, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/ffpa_pkg.sv
sv/ffpa_mem.sv
sv/ffpa_ctrl.sv
sv/first_fit_pool_allocator.sv
dv/first_fit_pool_allocator_test.sv
